### src/scf_pkg.sv
// Shared types, codes and helper functions of the chord score follower.
package scf_pkg;

  localparam logic [2:0] OP_LOAD_CHORD = 3'd0;
  localparam logic [2:0] OP_LOAD_PAGE  = 3'd1;
  localparam logic [2:0] OP_START      = 3'd2;
  localparam logic [2:0] OP_RESET_BAR  = 3'd3;
  localparam logic [2:0] OP_BAR_UP     = 3'd4;
  localparam logic [2:0] OP_BAR_DOWN   = 3'd5;
  localparam logic [2:0] OP_NOTE       = 3'd6;

  localparam logic [1:0] CFG_CHORD_COUNT = 2'd0;
  localparam logic [1:0] CFG_PAGE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SKIP_THRESH = 2'd2;

  localparam int BAR_W  = 16;
  localparam int MASK_W = 12;

  typedef struct packed {
    logic [BAR_W-1:0]  bar;
    logic [MASK_W-1:0] mask;
  } chord_entry_t;

  // note mod 12 through reciprocal multiply, exact for 7-bit notes
  function automatic logic [3:0] pitch_class(input logic [6:0] note);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 13'(note) * 13'd43;
    q    = prod[12:9];
    r    = note - 7'({3'd0, q} * 7'd12);
    return r[3:0];
  endfunction

  function automatic logic note_hits(input logic [MASK_W-1:0] mask,
                                     input logic              valid,
                                     input logic [6:0]        note);
    logic [3:0] pc;
    pc = pitch_class(note);
    return (mask == '0) || (valid && mask[pc]);
  endfunction

endpackage

### src/scf_tables.sv
// Chord and page-break table memories with registered read.
module scf_tables #(
  parameter int MAX_CHORDS = 256,
  parameter int MAX_PAGES  = 16
) (
  input  logic                         clk,
  input  logic                         chord_we,
  input  logic [$clog2(MAX_CHORDS)-1:0] chord_waddr,
  input  scf_pkg::chord_entry_t        chord_wdata,
  input  logic [$clog2(MAX_CHORDS)-1:0] chord_raddr,
  output scf_pkg::chord_entry_t        chord_rdata,
  input  logic                         page_we,
  input  logic [$clog2(MAX_PAGES)-1:0]  page_waddr,
  input  logic [scf_pkg::BAR_W-1:0]    page_wdata,
  input  logic [$clog2(MAX_PAGES)-1:0]  page_raddr,
  output logic [scf_pkg::BAR_W-1:0]    page_rdata
);

  scf_pkg::chord_entry_t          chord_mem [MAX_CHORDS];
  logic [scf_pkg::BAR_W-1:0]      page_mem  [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (chord_we) begin
      chord_mem[chord_waddr] <= chord_wdata;
    end
    chord_rdata <= chord_mem[chord_raddr];
  end

  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
    page_rdata <= page_mem[page_raddr];
  end

endmodule

### src/chord_score_follower_core.sv
// Chord score follower: top level with sequencer, state and result register.
// Loads, reset bar, idle ops, refused bar steps and notes past the song end go straight to
// the result; start first reads the last chord's bar. A word is taken only after the last
// result is registered. Bar step: reads and checks chord entries in turn (bar down stops at
// chord 0), then the page check. A note checks current, then lookahead chord, then settles.
// Reset: synchronous; position, held note and registers reset, tables keep contents.
module chord_score_follower_core #(
  parameter int MAX_CHORDS = 256,
  parameter int MAX_PAGES  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_index,
  input  logic [15:0] in_bar,
  input  logic [11:0] in_pitch_mask,
  input  logic [6:0]  in_note,
  input  logic        in_note_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_current_bar,
  output logic [4:0]  out_current_page,
  output logic [8:0]  out_chord_position,
  output logic [8:0]  out_lookahead_chord,
  output logic        out_page_turn,
  output logic        out_paused,
  output logic [6:0]  out_held_note,
  output logic        out_held_note_valid
);

  localparam int CW  = $clog2(MAX_CHORDS);
  localparam int CNW = $clog2(MAX_CHORDS + 1);
  localparam int CXW = CNW + 1;
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int PNW = $clog2(MAX_PAGES + 1);

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_EXEC       = 16'h0002,
    S_LAST_CHK   = 16'h0004,
    S_UP_RD      = 16'h0008,
    S_UP_CHK     = 16'h0010,
    S_DN_RD      = 16'h0020,
    S_DN_CHK     = 16'h0040,
    S_PGF_RD     = 16'h0080,
    S_PGF_CHK    = 16'h0100,
    S_PGB_RD     = 16'h0200,
    S_PGB_CHK    = 16'h0400,
    S_NOTE_CHK   = 16'h0800,
    S_AHEAD_CHK  = 16'h1000,
    S_SETTLE_RD  = 16'h2000,
    S_SETTLE_CHK = 16'h4000,
    S_DONE       = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  op_r;
  logic [7:0]  idx_r;
  logic [15:0] bar_in_r;
  logic [11:0] mask_r;
  logic [6:0]  note_r;
  logic        nvalid_r;

  logic [15:0]    bar_now_r, bar_now_nxt;
  logic [15:0]    last_bar_r, last_bar_nxt;
  logic [PNW-1:0] page_now_r, page_now_nxt;
  logic [PNW-1:0] page_before_r;
  logic [CNW-1:0] chord_now_r, chord_now_nxt;
  logic [CNW-1:0] chord_ahead_r, chord_ahead_nxt;
  logic [6:0]     note_now_r, note_now_nxt;
  logic           note_held_r, note_held_nxt;

  logic [8:0] chord_count_r;
  logic [4:0] page_count_r;
  logic [3:0] skip_thresh_r;

  logic        out_valid_r;
  logic [15:0] out_bar_r;
  logic [4:0]  out_page_r;
  logic [8:0]  out_chord_r;
  logic [8:0]  out_ahead_r;
  logic        out_turn_r;
  logic        out_paused_r;
  logic [6:0]  out_note_r;
  logic        out_note_valid_r;

  logic [CNW-1:0] n_chords;
  logic [PNW-1:0] n_pages;

  logic                  chord_we;
  logic [CW-1:0]         chord_raddr;
  scf_pkg::chord_entry_t chord_rdata;
  logic                  page_we;
  logic [PW-1:0]         page_raddr;
  logic [15:0]           page_rdata;

  logic [CXW-1:0] a1, a2, ahead_gap;
  logic           in_acc, out_free;

  function automatic logic [CNW-1:0] fix_ahead(input logic [CNW-1:0] c,
                                               input logic [CNW-1:0] n);
    logic [CXW-1:0] c1;
    c1 = {1'b0, c} + CXW'(1);
    return (c1 < {1'b0, n}) ? CNW'(c1) : c;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (chord_count_r == '0) begin
      n_chords = CNW'(1);
    end else if (32'(chord_count_r) > 32'(MAX_CHORDS)) begin
      n_chords = CNW'(MAX_CHORDS);
    end else begin
      n_chords = CNW'(chord_count_r);
    end
    if (page_count_r == '0) begin
      n_pages = PNW'(1);
    end else if (32'(page_count_r) > 32'(MAX_PAGES)) begin
      n_pages = PNW'(MAX_PAGES);
    end else begin
      n_pages = PNW'(page_count_r);
    end
  end

  // table access
  assign chord_we = (state_r == S_EXEC) && (op_r == scf_pkg::OP_LOAD_CHORD) &&
                    (32'(idx_r) < 32'(MAX_CHORDS));
  assign page_we  = (state_r == S_EXEC) && (op_r == scf_pkg::OP_LOAD_PAGE) &&
                    (32'(idx_r) < 32'(MAX_PAGES));

  always_comb begin
    case (state_r)
      S_EXEC: begin
        chord_raddr = (op_r == scf_pkg::OP_START) ? CW'(n_chords - CNW'(1))
                                                  : CW'(chord_now_r);
      end
      S_DN_RD:    chord_raddr = CW'(chord_now_r - CNW'(1));
      S_NOTE_CHK: chord_raddr = CW'(chord_ahead_r);
      default:    chord_raddr = CW'(chord_now_r);
    endcase
    if (state_r == S_PGB_RD) begin
      page_raddr = PW'(page_now_r - PNW'(2));
    end else begin
      page_raddr = PW'(page_now_r - PNW'(1));
    end
  end

  scf_tables #(
    .MAX_CHORDS(MAX_CHORDS),
    .MAX_PAGES (MAX_PAGES)
  ) u_tables (
    .clk        (clk),
    .chord_we   (chord_we),
    .chord_waddr(CW'(idx_r)),
    .chord_wdata({bar_in_r, mask_r}),
    .chord_raddr(chord_raddr),
    .chord_rdata(chord_rdata),
    .page_we    (page_we),
    .page_waddr (PW'(idx_r)),
    .page_wdata (bar_in_r),
    .page_raddr (page_raddr),
    .page_rdata (page_rdata)
  );

  assign a1        = {1'b0, chord_ahead_r} + CXW'(1);
  assign a2        = a1 + CXW'(1);
  assign ahead_gap = a1 - {1'b0, chord_now_r};

  always_comb begin
    state_nxt       = state_r;
    bar_now_nxt     = bar_now_r;
    last_bar_nxt    = last_bar_r;
    page_now_nxt    = page_now_r;
    chord_now_nxt   = chord_now_r;
    chord_ahead_nxt = chord_ahead_r;
    note_now_nxt    = note_now_r;
    note_held_nxt   = note_held_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          scf_pkg::OP_START: begin
            bar_now_nxt     = 16'd1;
            page_now_nxt    = PNW'(1);
            chord_now_nxt   = '0;
            chord_ahead_nxt = CNW'(1);
            note_now_nxt    = '0;
            note_held_nxt   = 1'b0;
            state_nxt       = S_LAST_CHK;
          end
          scf_pkg::OP_RESET_BAR: begin
            bar_now_nxt     = 16'd1;
            page_now_nxt    = PNW'(1);
            chord_now_nxt   = '0;
            chord_ahead_nxt = CNW'(1);
          end
          scf_pkg::OP_BAR_UP: begin
            if (bar_now_r < last_bar_r) begin
              bar_now_nxt = bar_now_r + 16'd1;
              state_nxt   = S_UP_RD;
            end
          end
          scf_pkg::OP_BAR_DOWN: begin
            if (bar_now_r > 16'd1) begin
              bar_now_nxt = bar_now_r - 16'd1;
              state_nxt   = S_DN_RD;
            end
          end
          scf_pkg::OP_NOTE: begin
            if (chord_now_r < n_chords) begin
              note_held_nxt = nvalid_r;
              note_now_nxt  = nvalid_r ? note_r : 7'd0;
              state_nxt     = S_NOTE_CHK;
            end
          end
          default: ;
        endcase
      end
      S_LAST_CHK: begin
        last_bar_nxt = chord_rdata.bar;
        state_nxt    = S_DONE;
      end
      S_UP_RD: begin
        if (chord_now_r < n_chords) begin
          state_nxt = S_UP_CHK;
        end else begin
          chord_ahead_nxt = fix_ahead(chord_now_r, n_chords);
          state_nxt       = S_PGF_RD;
        end
      end
      S_UP_CHK: begin
        if (chord_rdata.bar < bar_now_r) begin
          chord_now_nxt = chord_now_r + CNW'(1);
          state_nxt     = S_UP_RD;
        end else begin
          chord_ahead_nxt = fix_ahead(chord_now_r, n_chords);
          state_nxt       = S_PGF_RD;
        end
      end
      S_DN_RD: begin
        if (chord_now_r != '0) begin
          state_nxt = S_DN_CHK;
        end else begin
          chord_ahead_nxt = fix_ahead(chord_now_r, n_chords);
          state_nxt       = S_PGB_RD;
        end
      end
      S_DN_CHK: begin
        if (chord_rdata.bar >= bar_now_r) begin
          chord_now_nxt = chord_now_r - CNW'(1);
          state_nxt     = S_DN_RD;
        end else begin
          chord_ahead_nxt = fix_ahead(chord_now_r, n_chords);
          state_nxt       = S_PGB_RD;
        end
      end
      S_PGF_RD: begin
        if (page_now_r != '0 && page_now_r < n_pages) begin
          state_nxt = S_PGF_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PGF_CHK: begin
        if (bar_now_r >= page_rdata) begin
          page_now_nxt = page_now_r + PNW'(1);
        end
        state_nxt = S_DONE;
      end
      S_PGB_RD: begin
        if (page_now_r > PNW'(1)) begin
          state_nxt = S_PGB_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PGB_CHK: begin
        if (bar_now_r < page_rdata) begin
          page_now_nxt = page_now_r - PNW'(1);
        end
        state_nxt = S_DONE;
      end
      S_NOTE_CHK: begin
        if (scf_pkg::note_hits(chord_rdata.mask, nvalid_r, note_r)) begin
          chord_now_nxt   = chord_now_r + CNW'(1);
          chord_ahead_nxt = fix_ahead(chord_now_r + CNW'(1), n_chords);
          state_nxt       = S_SETTLE_RD;
        end else if (chord_ahead_r < n_chords) begin
          state_nxt = S_AHEAD_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_AHEAD_CHK: begin
        state_nxt = S_DONE;
        if (scf_pkg::note_hits(chord_rdata.mask, nvalid_r, note_r)) begin
          chord_ahead_nxt = CNW'(a1);
          if (32'(ahead_gap) > 32'(skip_thresh_r) || a1 >= {1'b0, n_chords}) begin
            chord_now_nxt = CNW'(a1);
            if (a2 < {1'b0, n_chords}) begin
              chord_ahead_nxt = CNW'(a2);
            end
            state_nxt = S_SETTLE_RD;
          end
        end
      end
      S_SETTLE_RD: begin
        if (chord_now_r < n_chords) begin
          state_nxt = S_SETTLE_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SETTLE_CHK: begin
        bar_now_nxt = chord_rdata.bar;
        state_nxt   = S_PGF_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bar_now_r     <= 16'd1;
      last_bar_r    <= '0;
      page_now_r    <= PNW'(1);
      chord_now_r   <= '0;
      chord_ahead_r <= CNW'(1);
      note_now_r    <= '0;
      note_held_r   <= 1'b0;
      chord_count_r <= 9'd1;
      page_count_r  <= 5'd1;
      skip_thresh_r <= 4'd4;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      bar_now_r     <= bar_now_nxt;
      last_bar_r    <= last_bar_nxt;
      page_now_r    <= page_now_nxt;
      chord_now_r   <= chord_now_nxt;
      chord_ahead_r <= chord_ahead_nxt;
      note_now_r    <= note_now_nxt;
      note_held_r   <= note_held_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          scf_pkg::CFG_CHORD_COUNT: chord_count_r <= cfg_data;
          scf_pkg::CFG_PAGE_COUNT:  page_count_r  <= cfg_data[4:0];
          scf_pkg::CFG_SKIP_THRESH: skip_thresh_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input word capture and result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r          <= in_op;
      idx_r         <= in_index;
      bar_in_r      <= in_bar;
      mask_r        <= in_pitch_mask;
      note_r        <= in_note;
      nvalid_r      <= in_note_valid;
      page_before_r <= page_now_r;
    end
    if (state_r == S_DONE && out_free) begin
      out_bar_r        <= bar_now_r;
      out_page_r       <= 5'(page_now_r);
      out_chord_r      <= 9'(chord_now_r);
      out_ahead_r      <= 9'(chord_ahead_r);
      out_turn_r       <= (page_now_r != page_before_r);
      out_paused_r     <= (chord_now_r >= n_chords);
      out_note_r       <= note_now_r;
      out_note_valid_r <= note_held_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_current_bar     = out_bar_r;
  assign out_current_page    = out_page_r;
  assign out_chord_position  = out_chord_r;
  assign out_lookahead_chord = out_ahead_r;
  assign out_page_turn       = out_turn_r;
  assign out_paused          = out_paused_r;
  assign out_held_note       = out_note_r;
  assign out_held_note_valid = out_note_valid_r;

endmodule

### test/tb_chord_score_follower_core.sv
// Self-checking testbench for the chord score follower core.
module tb_chord_score_follower_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHORD_DEPTH = 256;
  localparam int PAGE_DEPTH = 16;
  localparam logic [2:0] OP_IDLE = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  index;
    logic [15:0] bar;
    logic [11:0] mask;
    logic [6:0]  note;
    logic        nvalid;
  } in_word_t;

  typedef struct packed {
    logic [15:0] bar;
    logic [4:0]  page;
    logic [8:0]  chord;
    logic [8:0]  ahead;
    logic        turn;
    logic        paused;
    logic [6:0]  note;
    logic        note_ok;
  } result_t;

  // Tracks the follower position and queues the result each word should produce.
  class follower_model;
    logic [15:0] bar_tab[CHORD_DEPTH];
    logic [11:0] mask_tab[CHORD_DEPTH];
    logic [15:0] page_tab[PAGE_DEPTH];
    int unsigned bar_now, last_bar, page_now, chord_now, chord_ahead, note_now;
    bit note_held;
    int unsigned chord_reg, page_reg, skip_reg;
    result_t expected_results[$];
    int errors;

    function new();
      home();
      last_bar = 0;
      note_now = 0;
      note_held = 0;
      chord_reg = 1;
      page_reg = 1;
      skip_reg = 4;
      errors = 0;
    endfunction

    function int unsigned chords();
      if (chord_reg == 0) return 1;
      return chord_reg > CHORD_DEPTH ? CHORD_DEPTH : chord_reg;
    endfunction

    function int unsigned pages();
      if (page_reg == 0) return 1;
      return page_reg > PAGE_DEPTH ? PAGE_DEPTH : page_reg;
    endfunction

    function int unsigned bar_of(int unsigned c);
      return c < CHORD_DEPTH ? int'(bar_tab[c]) : 0;
    endfunction

    function bit hits(int unsigned c, bit v, logic [6:0] nt);
      logic [11:0] m;
      m = c < CHORD_DEPTH ? mask_tab[c] : 12'h0;
      if (m == 12'h0) return 1;
      if (!v) return 0;
      return m[nt % 12];
    endfunction

    function void home();
      bar_now = 1;
      page_now = 1;
      chord_now = 0;
      chord_ahead = 1;
    endfunction

    function void fix_ahead();
      chord_ahead = chord_now;
      if (chord_ahead + 1 < chords()) chord_ahead++;
    endfunction

    function void page_forward();
      if (page_now >= 1 && page_now < pages() && bar_now >= page_tab[page_now - 1])
        page_now++;
    endfunction

    function void settle();
      if (chord_now < chords()) begin
        bar_now = bar_of(chord_now);
        page_forward();
      end
    endfunction

    function void take_note(bit v, logic [6:0] nt);
      int unsigned n;
      n = chords();
      if (chord_now >= n) return;
      note_held = v;
      note_now = v ? int'(nt) : 0;
      if (hits(chord_now, v, nt)) begin
        chord_now++;
        fix_ahead();
        settle();
      end else if (chord_ahead < n && hits(chord_ahead, v, nt)) begin
        chord_ahead++;
        if (chord_ahead - chord_now > skip_reg || chord_ahead >= n) begin
          chord_now = chord_ahead;
          if (chord_ahead + 1 < n) chord_ahead++;
          settle();
        end
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        scf_pkg::CFG_CHORD_COUNT: chord_reg = val;
        scf_pkg::CFG_PAGE_COUNT:  page_reg = val[4:0];
        scf_pkg::CFG_SKIP_THRESH: skip_reg = val[3:0];
        default: ;
      endcase
    endfunction

    function void accept_word(in_word_t w);
      int unsigned page_before, n;
      result_t r;
      page_before = page_now;
      n = chords();
      case (w.op)
        scf_pkg::OP_LOAD_CHORD: begin
          bar_tab[w.index] = w.bar;
          mask_tab[w.index] = w.mask;
        end
        scf_pkg::OP_LOAD_PAGE: if (w.index < PAGE_DEPTH) page_tab[w.index] = w.bar;
        scf_pkg::OP_START: begin
          home();
          last_bar = bar_of(n - 1);
          note_now = 0;
          note_held = 0;
        end
        scf_pkg::OP_RESET_BAR: home();
        scf_pkg::OP_BAR_UP: if (bar_now < last_bar) begin
          bar_now++;
          while (chord_now < n && bar_of(chord_now) < bar_now) chord_now++;
          fix_ahead();
          page_forward();
        end
        scf_pkg::OP_BAR_DOWN: if (bar_now > 1) begin
          bar_now--;
          while (chord_now > 0 && bar_of(chord_now - 1) >= bar_now) chord_now--;
          fix_ahead();
          if (page_now > 1 && page_now - 2 < PAGE_DEPTH &&
              bar_now < page_tab[page_now - 2])
            page_now--;
        end
        scf_pkg::OP_NOTE: take_note(w.nvalid, w.note);
        default: ;
      endcase
      r.bar = bar_now[15:0];
      r.page = page_now[4:0];
      r.chord = chord_now[8:0];
      r.ahead = chord_ahead[8:0];
      r.turn = page_now != page_before;
      r.paused = chord_now >= n;
      r.note = note_now[6:0];
      r.note_ok = note_held;
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none, got %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("current_bar", want.bar, got.bar);
      check_field("current_page", 16'(want.page), 16'(got.page));
      check_field("chord_position", 16'(want.chord), 16'(got.chord));
      check_field("lookahead_chord", 16'(want.ahead), 16'(got.ahead));
      check_field("page_turn", 16'(want.turn), 16'(got.turn));
      check_field("paused", 16'(want.paused), 16'(got.paused));
      check_field("held_note", 16'(want.note), 16'(got.note));
      check_field("held_note_valid", 16'(want.note_ok), 16'(got.note_ok));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_index = '0;
  logic [15:0] in_bar = '0;
  logic [11:0] in_pitch_mask = '0;
  logic [6:0]  in_note = '0;
  logic        in_note_valid = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_current_bar;
  logic [4:0]  out_current_page;
  logic [8:0]  out_chord_position;
  logic [8:0]  out_lookahead_chord;
  logic        out_page_turn;
  logic        out_paused;
  logic [6:0]  out_held_note;
  logic        out_held_note_valid;

  follower_model sb;
  int tx_idle = 0;
  int rx_idle = 0;
  logic long_hold = 1'b0;
  int stall_cycles = 0;
  event hold_ev;

  chord_score_follower_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_index(in_index),
    .in_bar(in_bar),
    .in_pitch_mask(in_pitch_mask),
    .in_note(in_note),
    .in_note_valid(in_note_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_current_bar(out_current_bar),
    .out_current_page(out_current_page),
    .out_chord_position(out_chord_position),
    .out_lookahead_chord(out_lookahead_chord),
    .out_page_turn(out_page_turn),
    .out_paused(out_paused),
    .out_held_note(out_held_note),
    .out_held_note_valid(out_held_note_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !long_hold && ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.compare_result('{out_current_bar, out_current_page, out_chord_position,
                          out_lookahead_chord, out_page_turn, out_paused,
                          out_held_note, out_held_note_valid});
  end

  // long receiver hold-off so the core backs up into its input
  always begin
    @(hold_ev);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_word_t rand_word(logic [2:0] op);
    in_word_t w;
    w.op = op;
    w.index = 8'($urandom_range(0, 255));
    w.bar = 16'($urandom_range(0, 65535));
    w.mask = 12'($urandom_range(0, 4095));
    w.note = 7'($urandom_range(0, 127));
    w.nvalid = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [11:0] song_mask();
    logic [11:0] m;
    m = '0;
    if ($urandom_range(0, 7) == 0) return m;
    repeat ($urandom_range(1, 3)) m[$urandom_range(0, 11)] = 1'b1;
    return m;
  endfunction

  function automatic logic [6:0] note_in(logic [11:0] m);
    int pc;
    if (m == '0) return 7'($urandom_range(0, 127));
    do pc = $urandom_range(0, 11); while (!m[pc]);
    return 7'(pc + 12 * $urandom_range(0, (127 - pc) / 12));
  endfunction

  function automatic in_word_t chord_note();
    in_word_t w;
    logic [11:0] m;
    w = rand_word(scf_pkg::OP_NOTE);
    m = sb.chord_now < CHORD_DEPTH ? sb.mask_tab[sb.chord_now] : 12'h0;
    w.note = note_in(m);
    if (m != '0) w.nvalid = 1'b1;
    return w;
  endfunction

  // prefer a pitch class in the lookahead chord that the current chord lacks
  function automatic in_word_t ahead_note();
    in_word_t w;
    logic [11:0] m_a, m_n;
    w = rand_word(scf_pkg::OP_NOTE);
    if (sb.chord_ahead >= CHORD_DEPTH) return w;
    m_a = sb.mask_tab[sb.chord_ahead];
    m_n = sb.chord_now < CHORD_DEPTH ? sb.mask_tab[sb.chord_now] : 12'h0;
    w.note = note_in((m_a & ~m_n) != '0 ? (m_a & ~m_n) : m_a);
    w.nvalid = 1'b1;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= w.op;
    in_index <= w.index;
    in_bar <= w.bar;
    in_pitch_mask <= w.mask;
    in_note <= w.note;
    in_note_valid <= w.nvalid;
    do @(posedge clk); while (!in_ready);
    sb.accept_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(logic [8:0] cc, logic [8:0] pc, logic [8:0] st);
    logic [1:0] reg_idx;
    logic [8:0] reg_val;
    for (int i = 0; i < 3; i++) begin
      reg_idx = i == 0 ? scf_pkg::CFG_CHORD_COUNT :
                i == 1 ? scf_pkg::CFG_PAGE_COUNT : scf_pkg::CFG_SKIP_THRESH;
      reg_val = i == 0 ? cc : i == 1 ? pc : st;
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx;
      cfg_data <= reg_val;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(reg_idx, reg_val);
    end
    cfg_valid <= 1'b0;
  endtask

  // chords on non-decreasing bars, page breaks spread evenly over the song
  task automatic load_song(int n_load, int np);
    int b;
    in_word_t w;
    b = $urandom_range(1, 3);
    for (int i = 0; i < n_load; i++) begin
      w = rand_word(scf_pkg::OP_LOAD_CHORD);
      w.index = 8'(i);
      w.bar = 16'(b);
      w.mask = song_mask();
      send_word(w);
      b += ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 2);
    end
    for (int p = 0; p < PAGE_DEPTH; p++) begin
      w = rand_word(scf_pkg::OP_LOAD_PAGE);
      w.index = 8'(p);
      w.bar = 16'(1 + (p + 1) * (n_load + 2) / np);
      send_word(w);
    end
  endtask

  task automatic play(int count);
    in_word_t w;
    int r, skip_left;
    skip_left = 0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (skip_left > 0) begin
        w = ahead_note();
        skip_left--;
      end else if (sb.chord_now >= sb.chords() && r < 40) begin
        w = rand_word(scf_pkg::OP_START);
      end else if (r < 55) begin
        w = chord_note();
      end else if (r < 63) begin
        skip_left = $urandom_range(1, sb.skip_reg + 3) - 1;
        w = ahead_note();
      end else if (r < 70) begin
        w = rand_word(scf_pkg::OP_NOTE);
      end else if (r < 76) begin
        w = rand_word(scf_pkg::OP_BAR_UP);
      end else if (r < 81) begin
        w = rand_word(scf_pkg::OP_BAR_DOWN);
      end else if (r < 83) begin
        w = rand_word(scf_pkg::OP_RESET_BAR);
      end else if (r < 84) begin
        w = rand_word(OP_IDLE);
      end else if (r < 89) begin
        w = rand_word(scf_pkg::OP_LOAD_CHORD);
      end else if (r < 91) begin
        w = rand_word(scf_pkg::OP_LOAD_PAGE);
        w.index = 8'($urandom_range(0, 31));
      end else if (r < 93) begin
        w = rand_word(scf_pkg::OP_START);
      end else begin
        w = chord_note();
      end
      send_word(w);
    end
  endtask

  initial begin
    in_word_t w;
    int cc, pc, st, n;
    sb = new();
    tx_idle = 6;
    rx_idle <= 67;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ops that touch no table before anything is loaded
    send_word(rand_word(OP_IDLE));
    send_word(rand_word(scf_pkg::OP_RESET_BAR));
    send_word(rand_word(scf_pkg::OP_BAR_UP));
    send_word(rand_word(scf_pkg::OP_BAR_DOWN));
    drain();
    set_regs(9'd256, 9'd16, 9'd15);

    // fill every table entry so no later read hits an unwritten one
    load_song(CHORD_DEPTH, PAGE_DEPTH);

    w = rand_word(scf_pkg::OP_LOAD_CHORD);
    w.index = 8'hFF;
    w.bar = 16'hFFFF;
    w.mask = 12'hFFF;
    send_word(w);
    w = rand_word(scf_pkg::OP_LOAD_CHORD);
    w.index = 8'h00;
    w.bar = 16'd1;
    w.mask = 12'h000;
    send_word(w);
    w = rand_word(scf_pkg::OP_LOAD_PAGE);
    w.index = 8'hFF;
    w.bar = 16'hFFFF;
    send_word(w);
    w.index = 8'd16;
    send_word(w);
    send_word(rand_word(scf_pkg::OP_START));
    w = rand_word(scf_pkg::OP_NOTE);
    w.note = 7'd0;
    w.nvalid = 1'b0;
    send_word(w);
    send_word(w);
    w.note = 7'd127;
    w.nvalid = 1'b1;
    send_word(w);
    w.note = 7'd0;
    send_word(w);
    send_word(rand_word(scf_pkg::OP_BAR_UP));
    send_word(rand_word(scf_pkg::OP_BAR_UP));
    send_word(rand_word(scf_pkg::OP_BAR_DOWN));
    send_word(rand_word(scf_pkg::OP_BAR_DOWN));
    send_word(rand_word(scf_pkg::OP_BAR_DOWN));
    send_word(rand_word(scf_pkg::OP_RESET_BAR));
    send_word('{OP_IDLE, 8'hFF, 16'hFFFF, 12'hFFF, 7'h7F, 1'b1});
    send_word('{OP_IDLE, 8'h00, 16'h0000, 12'h000, 7'h00, 1'b0});

    for (int s = 0; s < 12; s++) begin
      if (s == 4) begin
        tx_idle = 67;
        rx_idle <= 6;
      end else if (s == 8) begin
        tx_idle = 0;
        rx_idle <= 0;
      end
      if (s > 0) begin
        case (s)
          1: begin cc = 1; pc = 1; st = 1; end
          2: begin cc = 2; pc = 2; st = 0; end
          5: begin cc = 0; pc = 0; st = $urandom_range(0, 15); end
          9: begin cc = 300; pc = 31; st = $urandom_range(0, 15); end
          default: begin
            cc = $urandom_range(3, 40);
            pc = $urandom_range(1, 16);
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
          end
        endcase
        drain();
        set_regs(9'(cc), 9'(pc), 9'(st));
        n = sb.chords();
        load_song(n > 48 ? 48 : n, sb.pages());
        send_word(rand_word(scf_pkg::OP_START));
      end
      if (s == 3) -> hold_ev;
      play(100);
    end

    drain();
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
